### hw/rtl/bb3_pkg.sv
// Shared types, register codes, and arithmetic helpers for the 3x3 RGB box blur.
package bb3_pkg;

    // Configuration port
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 13;
    localparam int FRAME_WIDTH_W   = 11;
    localparam int FRAME_HEIGHT_W  = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Pixel format
    localparam logic [7:0] ALPHA_BYTE = 8'hFF;

    // Divide by 9 as a multiply by ceil(2^15 / 9) and a shift; exact for sums up to 9 * 255
    localparam int         DIV9_SHIFT = 15;
    localparam logic [11:0] DIV9_MUL  = 12'd3641;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // Sum of one window column (three pixels)
    typedef struct packed {
        logic [9:0] r;
        logic [9:0] g;
        logic [9:0] b;
    } t_col_sum;

    // Sum of the whole window (up to three columns)
    typedef struct packed {
        logic [11:0] r;
        logic [11:0] g;
        logic [11:0] b;
    } t_win_sum;

    // Per-item control carried down the pipeline
    typedef struct packed {
        logic use_top;
        logic use_mid;
        logic edge_col;
        logic emit;
        logic last;
    } t_item_ctl;

    function automatic t_col_sum col_add(t_rgb a, t_rgb b, t_rgb c);
        t_col_sum s;
        s.r = 10'(a.r) + 10'(b.r) + 10'(c.r);
        s.g = 10'(a.g) + 10'(b.g) + 10'(c.g);
        s.b = 10'(a.b) + 10'(b.b) + 10'(c.b);
        return s;
    endfunction

    function automatic t_win_sum win_add(t_col_sum a, t_col_sum b, t_col_sum c);
        t_win_sum s;
        s.r = 12'(a.r) + 12'(b.r) + 12'(c.r);
        s.g = 12'(a.g) + 12'(b.g) + 12'(c.g);
        s.b = 12'(a.b) + 12'(b.b) + 12'(c.b);
        return s;
    endfunction

    function automatic logic [7:0] div9(logic [11:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'(DIV9_MUL);
        return p[DIV9_SHIFT+7:DIV9_SHIFT];
    endfunction

endpackage

### hw/rtl/bb3_line_store.sv
// One line of RGB pixels: single write port, registered read with same-edge write bypass.
module bb3_line_store
    import bb3_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  t_rgb                     i_wr_data,
    output t_rgb                     o_rd_data
);

    localparam int AW = $clog2(DEPTH);

    t_rgb          r_mem [DEPTH];
    t_rgb          r_rd_data;
    t_rgb          r_byp_data;
    logic          r_byp_hit;

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // Flag a read that collides with a write on the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_byp_hit <= i_wr_en && (i_wr_addr == AW'(i_rd_addr));
        end
    end

    assign o_rd_data = r_byp_hit ? r_byp_data : r_rd_data;

endmodule

### hw/rtl/bb3_col_cell.sv
// One window column cell: holds a column sum and takes its neighbor's value on each shift.
module bb3_col_cell
    import bb3_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_shift,
    input  logic     i_clear,
    input  t_col_sum i_col,
    output t_col_sum o_col
);

    t_col_sum r_col;

    // Load the neighbor's column, or zero at the start of a line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_clear ? t_col_sum'('0) : i_col;
        end
    end

    assign o_col = r_col;

endmodule

### hw/rtl/box_blur_3x3_rgb_top.sv
// 3x3 box blur on a raster RGBA8888 stream: line stores, column cell chain, divide by 9.
// Throughput: one item per cycle unless output back-pressure stalls; all stages advance
// independently and collapse bubbles. An accepted item passes the line store read, window
// shift, window sum and divide into the output register; in stream terms an output
// pixel follows its input pixel by frame_width + 1 items.
// Reset: synchronous active low; clears positions, window, valids, registers to 640 x 480.
module box_blur_3x3_rgb_top
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_pixel_word,
    input  logic                  i_drain,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_out_pixel,
    output logic                  o_frame_end
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int WCW = (WW > FRAME_WIDTH_W) ? WW : FRAME_WIDTH_W;
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int HCW = (RW > FRAME_HEIGHT_W) ? RW : FRAME_HEIGHT_W;

    // Configuration
    logic [FRAME_WIDTH_W-1:0]  r_frame_width;
    logic [FRAME_HEIGHT_W-1:0] r_frame_height;
    logic                      cfg_hit;

    // Input position
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // Pipeline
    logic      r_s1_valid;
    t_item_ctl r_s1_ctl;
    logic [CW-1:0] r_s1_col;
    t_rgb      r_s1_pix;

    logic      r_s2_valid;
    t_item_ctl r_s2_ctl;
    t_win_sum  r_s2_edge_sum;

    logic      r_s3_valid;
    logic      r_s3_last;
    t_win_sum  r_s3_sum;

    logic      r_o_valid;
    logic [31:0] r_o_pix;
    logic      r_o_last;

    // Combinational
    logic [WCW-1:0] fw_ext;
    logic [HCW-1:0] fh_ext;
    logic [WW-1:0]  w_eff;
    logic [RW-1:0]  h_eff;
    logic [RW-1:0]  h_p1;
    logic [CW-1:0]  ic_eff;
    logic [WW-1:0]  col_inc;
    logic           ic0;
    logic           row_ge1;
    logic           row_ge2;
    t_item_ctl      in_ctl;
    logic           zero_px;
    logic           accept;
    logic           out_load_ok;
    logic           s3_ready;
    logic           s2_ready;
    logic           s1_ready;
    logic           s1_go;
    t_rgb           upper_rd;
    t_rgb           middle_rd;
    t_rgb           top_m;
    t_rgb           mid_m;
    t_col_sum       new_col;
    t_col_sum       cell_in  [3];
    t_col_sum       cell_out [3];

    // Configuration registers
    assign cfg_hit = i_cfg_we &&
                     (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[FRAME_WIDTH_W-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[FRAME_HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp frame size to the supported range
    assign fw_ext = WCW'(r_frame_width);
    assign fh_ext = HCW'(r_frame_height);
    assign w_eff  = (fw_ext == '0) ? WW'(1) :
                    (fw_ext > WCW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_ext);
    assign h_eff  = (fh_ext == '0) ? RW'(1) :
                    (fh_ext > HCW'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(fh_ext);
    assign h_p1   = h_eff + RW'(1);

    // Decide what the incoming item does at its position
    assign ic_eff  = (WW'(r_col) >= w_eff) ? '0 : r_col;
    assign col_inc = WW'(ic_eff) + WW'(1);
    assign ic0     = (ic_eff == '0);
    assign row_ge1 = (r_row != '0);
    assign row_ge2 = (r_row >= RW'(2));
    assign zero_px = i_drain || (r_row >= h_eff);

    always_comb begin
        in_ctl.use_top  = row_ge2;
        in_ctl.use_mid  = row_ge1;
        in_ctl.edge_col = ic0;
        in_ctl.emit     = ic0 ? (row_ge2 && (r_row <= h_p1)) : (row_ge1 && (r_row <= h_eff));
        in_ctl.last     = ic0 && row_ge2 && (r_row == h_p1);
    end

    // Handshake chain: every stage moves when the next one is free or moving
    assign out_load_ok = !r_o_valid || i_out_ready;
    assign s3_ready    = !r_s3_valid || out_load_ok;
    assign s2_ready    = !r_s2_valid || s3_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign s1_go       = r_s1_valid && s2_ready;
    assign accept      = i_in_valid && s1_ready;
    assign o_in_ready  = s1_ready;

    // Advance the input position; restart the frame on a frame size register write or frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (in_ctl.last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (col_inc >= w_eff) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= col_inc[CW-1:0];
            end
        end
    end

    // Stage 1: line store read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl <= in_ctl;
            r_s1_col <= ic_eff;
            r_s1_pix <= zero_px ? t_rgb'('0) : t_rgb'(i_pixel_word[31:8]);
        end
    end

    bb3_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (ic_eff),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data (mid_m),
        .o_rd_data (upper_rd)
    );

    bb3_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (ic_eff),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data (r_s1_pix),
        .o_rd_data (middle_rd)
    );

    // Mask rows above the top of the frame and form the new column sum
    assign top_m   = r_s1_ctl.use_top ? upper_rd  : t_rgb'('0);
    assign mid_m   = r_s1_ctl.use_mid ? middle_rd : t_rgb'('0);
    assign new_col = col_add(top_m, mid_m, r_s1_pix);

    // Window: a chain of column cells, newest on the right
    assign cell_in[2] = new_col;
    assign cell_in[1] = cell_out[2];
    assign cell_in[0] = cell_out[1];

    for (genvar k = 0; k < 3; k++) begin : g_cell
        bb3_col_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (s1_go),
            .i_clear ((k < 2) ? r_s1_ctl.edge_col : 1'b0),
            .i_col   (cell_in[k]),
            .o_col   (cell_out[k])
        );
    end

    // Stage 2: window updated; keep the right-edge sum of the window it replaced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_ctl      <= r_s1_ctl;
            r_s2_edge_sum <= win_add(t_col_sum'('0), cell_out[1], cell_out[2]);
        end
    end

    // Stage 3: window sum; drop items that make no output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_ready) begin
            r_s3_valid <= r_s2_valid && r_s2_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && r_s2_valid) begin
            r_s3_last <= r_s2_ctl.last;
            r_s3_sum  <= r_s2_ctl.edge_col ? r_s2_edge_sum
                                           : win_add(cell_out[0], cell_out[1], cell_out[2]);
        end
    end

    // Output register: divide by 9 and pack with opaque alpha
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load_ok) begin
            r_o_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load_ok && r_s3_valid) begin
            r_o_pix  <= {div9(r_s3_sum.r), div9(r_s3_sum.g), div9(r_s3_sum.b), ALPHA_BYTE};
            r_o_last <= r_s3_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_pixel = r_o_pix;
    assign o_frame_end = r_o_last;

endmodule
